FILE: rtl/u2a_pkg.sv
// Shared types, constants and the digit-to-character function for the ASCII formatter.
`default_nettype none

package u2a_pkg;

  // Field widths and digit-chain geometry.
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  // Format selector codes.
  localparam logic FUNC_DEC = 1'b0;
  localparam logic FUNC_HEX = 1'b1;

  // Characters of the hex prefix.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X    = 8'h78;

  // Input transaction payload.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               func;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // Controls that every digit cell receives in a cycle.
  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic adjust;
    logic shift_digit;
  } cell_ctl_t;

  // Upper-case hex character for one digit; decimal digits map to the same codes.
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    begin
      case (d)
        4'h0: c = 8'h30;
        4'h1: c = 8'h31;
        4'h2: c = 8'h32;
        4'h3: c = 8'h33;
        4'h4: c = 8'h34;
        4'h5: c = 8'h35;
        4'h6: c = 8'h36;
        4'h7: c = 8'h37;
        4'h8: c = 8'h38;
        4'h9: c = 8'h39;
        4'hA: c = 8'h41;
        4'hB: c = 8'h42;
        4'hC: c = 8'h43;
        4'hD: c = 8'h44;
        4'hE: c = 8'h45;
        default: c = 8'h46;
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/u32_to_ascii_dec_hex_core.sv
// Top level of the 32-bit binary to ASCII decimal/hex formatter.
`default_nettype none

// Formats one 32-bit unsigned value per input transaction as ASCII, most significant
// character first, one result transaction per character with last set on the final one.
// Decimal mode (func 0) drops leading zeros and gives a single '0' for zero; hex mode
// (func 1) gives "0x" and eight upper-case digits. The value is shifted bit by bit into
// a chain of ten digit cells (double dabble in decimal, plain shift in hex); the cells
// then move one digit per cycle, unless a shown character waits on a stalled output,
// toward the top cell, which feeds the output register. Each leading zero skipped in
// decimal still takes a shift of the chain. The block works on one item at a time and
// holds in_stall high meanwhile.
module u32_to_ascii_dec_hex_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire u2a_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output u2a_pkg::out_t      out_data
);

  localparam int ND = u2a_pkg::NUM_DIGITS;
  localparam int DW = u2a_pkg::DIGIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [u2a_pkg::BIT_CNT_W-1:0] LAST_BIT =
    u2a_pkg::BIT_CNT_W'(u2a_pkg::VALUE_W - 1);
  localparam logic [u2a_pkg::REM_W-1:0] REM_FULL = u2a_pkg::REM_W'(ND);
  localparam logic [u2a_pkg::REM_W-1:0] REM_XCHR = u2a_pkg::REM_W'(ND - 1);
  localparam logic [u2a_pkg::REM_W-1:0] REM_ONE  = u2a_pkg::REM_W'(1);

  logic [1:0]                        state_r, state_nxt;
  logic [u2a_pkg::VALUE_W-1:0]       val_r, val_nxt;
  logic                              func_r, func_nxt;
  logic [u2a_pkg::BIT_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [u2a_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic                              seen_nz_r, seen_nz_nxt;
  logic                              out_valid_r, out_valid_nxt;
  u2a_pkg::out_t                     out_data_r, out_data_nxt;

  u2a_pkg::cell_ctl_t                ctl;
  logic [ND-1:0]                     bit_out;
  logic [ND-1:0]                     bit_in;
  logic [DW-1:0]                     digit_out [ND];
  logic [DW-1:0]                     digit_in  [ND];

  logic [DW-1:0]                     top_digit;
  logic                              emit_ok;
  logic                              slot_free;
  logic                              step;
  logic [7:0]                        char_sel;

  // Chain of digit cells; cell 0 takes the value's top bit and a zero digit.
  genvar gi;
  generate
    for (gi = 0; gi < ND; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign bit_in[gi]   = val_r[u2a_pkg::VALUE_W-1];
        assign digit_in[gi] = '0;
      end else begin : g_rest
        assign bit_in[gi]   = bit_out[gi-1];
        assign digit_in[gi] = digit_out[gi-1];
      end
      u2a_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (bit_in[gi]),
        .digit_in  (digit_in[gi]),
        .bit_out   (bit_out[gi]),
        .digit_out (digit_out[gi])
      );
    end
  endgenerate

  assign top_digit = digit_out[ND-1];
  assign slot_free = !out_valid_r || !out_stall;

  // A character is shown unless it is a leading zero of a decimal run.
  assign emit_ok = (func_r == u2a_pkg::FUNC_HEX) || (top_digit != '0) || seen_nz_r ||
                   (rem_r == REM_ONE) || bit_out[ND-1];
  assign step    = (state_r == ST_EMIT) && (!emit_ok || slot_free);

  // Hex runs open with the prefix; the top cells hold zeros there.
  always_comb begin
    if ((func_r == u2a_pkg::FUNC_HEX) && (rem_r == REM_FULL)) begin
      char_sel = u2a_pkg::CHAR_ZERO;
    end else if ((func_r == u2a_pkg::FUNC_HEX) && (rem_r == REM_XCHR)) begin
      char_sel = u2a_pkg::CHAR_X;
    end else begin
      char_sel = u2a_pkg::digit_char(top_digit);
    end
  end

  // Sequencer: accept, convert bit by bit, then walk the digits out.
  always_comb begin
    state_nxt       = state_r;
    val_nxt         = val_r;
    func_nxt        = func_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    seen_nz_nxt     = seen_nz_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    ctl             = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.clear = 1'b1;
          val_nxt   = in_data.value;
          func_nxt  = in_data.func;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.shift_bit = 1'b1;
        ctl.adjust    = (func_r == u2a_pkg::FUNC_DEC);
        val_nxt       = {val_r[u2a_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          rem_nxt     = REM_FULL;
          seen_nz_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step) begin
          ctl.shift_digit = 1'b1;
          rem_nxt         = rem_r - 1'b1;
          if (top_digit != '0) begin
            seen_nz_nxt = 1'b1;
          end
          if (emit_ok) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.char_code = char_sel;
            out_data_nxt.last      = (rem_r == REM_ONE);
          end
          if (rem_r == REM_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    func_r     <= func_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    seen_nz_r  <= seen_nz_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/u2a_cell.sv
// One digit cell of the shift chain: double-dabble step, raw nibble shift or digit move.
`default_nettype none

module u2a_cell (
  input  wire logic                           clk,
  input  wire u2a_pkg::cell_ctl_t             ctl,
  input  wire logic                           bit_in,
  input  wire logic [u2a_pkg::DIGIT_W-1:0]    digit_in,
  output logic                                bit_out,
  output logic [u2a_pkg::DIGIT_W-1:0]         digit_out
);

  logic [u2a_pkg::DIGIT_W-1:0] digit_r;
  logic [u2a_pkg::DIGIT_W-1:0] digit_nxt;
  logic [u2a_pkg::DIGIT_W-1:0] adj;

  // Add three to a digit of five or more before the shift in decimal mode.
  always_comb begin
    if (ctl.adjust && (digit_r >= 4'd5)) begin
      adj = digit_r + 4'd3;
    end else begin
      adj = digit_r;
    end
  end

  // The bit shifted out goes to the next higher cell in the same cycle.
  assign bit_out   = adj[u2a_pkg::DIGIT_W-1];
  assign digit_out = digit_r;

  // Next digit: cleared, shifted by one bit, or taken from the lower neighbor.
  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift_bit) begin
      digit_nxt = {adj[u2a_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctl.shift_digit) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire
